FILE: src/gws_pkg.sv
// Package with shared constants, types and match functions for the grid word search.
package gws_pkg;

   localparam int DEFAULT_MAX_DIM = 128;
   localparam int WORD_LEN = 5;
   localparam int PROG_W = 3;
   localparam int CHAR_W = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'b1;

   localparam logic [PROG_W-1:0] PROG_FULL = PROG_W'(WORD_LEN);

   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last_cell;
   } pos_flags_type;

   function automatic logic [CHAR_W-1:0] word_char(input logic [PROG_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         3'd0: c = "s";
         3'd1: c = "p";
         3'd2: c = "o";
         3'd3: c = "o";
         3'd4: c = "n";
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] r;
      r = ch;
      if (ch >= "A" && ch <= "Z") begin
         r = ch + CHAR_W'(8'd32);
      end
      return r;
   endfunction

   function automatic logic [PROG_W-1:0] advance(input logic [PROG_W-1:0] prog,
                                                 input logic [CHAR_W-1:0] ch);
      logic [PROG_W-1:0] r;
      if (prog < PROG_FULL && ch == word_char(prog)) begin
         r = prog + PROG_W'(1);
      end else if (ch == word_char('0)) begin
         r = PROG_W'(1);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

FILE: src/grid_word_search_rows_columns.sv
// Top level of the grid word search for "spoon" along rows and columns.
// One character transfer per cycle is sustained unless the input stalls; the column memory is read
// at acceptance and written back when stage s1 fires, with forwarding when consecutive characters
// hit one column. rsp_valid is registered and rises once the last cell of a grid leaves stage s1;
// the input stalls only while a finished grid waits behind a result that has not been taken.
// Synchronous reset clears counters, progress and rsp_valid; rsp_found and the column memory are not cleared.
module grid_word_search_rows_columns #(
   parameter int MAX_DIM = gws_pkg::DEFAULT_MAX_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gws_pkg::CHAR_W-1:0]    req_char_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   input  logic                          csr_wr_en,
   input  logic [gws_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gws_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import gws_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM);

   logic [CSR_DATA_W-1:0] row_count_ff, row_count_in;
   logic [CSR_DATA_W-1:0] column_count_ff, column_count_in;

   logic                  accept;
   logic [IDX_W-1:0]      col_index;
   pos_flags_type         flags;

   logic                  s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0]     s1_char_ff;
   logic [IDX_W-1:0]      s1_col_ff;
   pos_flags_type         s1_flags_ff;
   logic                  s1_stall, s1_fire;

   logic [PROG_W-1:0]     col_rd_data;
   logic [PROG_W-1:0]     hprev, vprev, hnew, vnew;
   logic [PROG_W-1:0]     row_prog_ff, row_prog_in;
   logic                  found_ff, found_in, found_next;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;

   always_comb begin
      row_count_in = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wr_data;
            CSR_COLUMN_COUNT: column_count_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CSR_DATA_W'(1);
         column_count_ff <= CSR_DATA_W'(1);
      end else begin
         row_count_ff <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   assign s1_stall = s1_valid_ff && s1_flags_ff.last_cell && rsp_valid_ff && !rsp_ready;
   assign s1_fire = s1_valid_ff && !s1_stall;
   assign req_ready = !s1_stall;
   assign accept = req_valid && req_ready;

   gws_pos_ctr #(
      .MAX_DIM(MAX_DIM),
      .IDX_W(IDX_W)
   ) u_pos (
      .clock(clock),
      .reset(reset),
      .step(accept),
      .row_count(row_count_ff),
      .column_count(column_count_ff),
      .col_index(col_index),
      .flags(flags)
   );

   gws_col_mem #(
      .MAX_DIM(MAX_DIM),
      .IDX_W(IDX_W)
   ) u_mem (
      .clock(clock),
      .reset(reset),
      .rd_en(accept),
      .rd_addr(col_index),
      .rd_data(col_rd_data),
      .wr_en(s1_fire),
      .wr_addr(s1_col_ff),
      .wr_data(vnew)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_ff <= fold_char(req_char_in);
         s1_col_ff <= col_index;
         s1_flags_ff <= flags;
      end
   end

   always_comb begin
      hprev = s1_flags_ff.first_col ? '0 : row_prog_ff;
      vprev = s1_flags_ff.first_row ? '0 : col_rd_data;
      hnew = advance(hprev, s1_char_ff);
      vnew = advance(vprev, s1_char_ff);
      found_next = found_ff || (hnew == PROG_FULL) || (vnew == PROG_FULL);
      row_prog_in = row_prog_ff;
      found_in = found_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         if (s1_flags_ff.last_cell) begin
            row_prog_in = '0;
            found_in = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            row_prog_in = hnew;
            found_in = found_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         row_prog_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         row_prog_ff <= row_prog_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_flags_ff.last_cell) begin
         rsp_found_ff <= found_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

FILE: src/gws_col_mem.sv
// Column progress memory with registered read and write-to-read forwarding.
module gws_col_mem #(
   parameter int MAX_DIM = gws_pkg::DEFAULT_MAX_DIM,
   parameter int IDX_W = $clog2(MAX_DIM)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [gws_pkg::PROG_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [gws_pkg::PROG_W-1:0] wr_data
);
   import gws_pkg::*;

   logic [PROG_W-1:0] mem [MAX_DIM];
   logic [PROG_W-1:0] rdata_ff;
   logic              fwd_ff;
   logic              fwd_in;
   logic [PROG_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      fwd_in = fwd_ff;
      if (rd_en) begin
         fwd_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

FILE: src/gws_pos_ctr.sv
// Raster position counters that flag the first row, first column and last cell.
module gws_pos_ctr #(
   parameter int MAX_DIM = gws_pkg::DEFAULT_MAX_DIM,
   parameter int IDX_W = $clog2(MAX_DIM)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [gws_pkg::CSR_DATA_W-1:0] row_count,
   input  logic [gws_pkg::CSR_DATA_W-1:0] column_count,
   output logic [IDX_W-1:0]              col_index,
   output gws_pkg::pos_flags_type        flags
);
   import gws_pkg::*;

   localparam int CMP_W = (IDX_W + 1 > CSR_DATA_W) ? IDX_W + 1 : CSR_DATA_W;

   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [CMP_W-1:0] rows, cols;
   logic [CMP_W-1:0] row_plus, col_plus;
   logic             row_end, grid_end;

   function automatic logic [CMP_W-1:0] clamp(input logic [CSR_DATA_W-1:0] v);
      logic [CMP_W-1:0] e;
      e = CMP_W'(v);
      if (e == '0) begin
         e = CMP_W'(1);
      end else if (e > CMP_W'(MAX_DIM)) begin
         e = CMP_W'(MAX_DIM);
      end
      return e;
   endfunction

   always_comb begin
      rows = clamp(row_count);
      cols = clamp(column_count);
      row_plus = CMP_W'(row_ff) + CMP_W'(1);
      col_plus = CMP_W'(col_ff) + CMP_W'(1);
      row_end = col_plus >= cols;
      grid_end = row_end && (row_plus >= rows);
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (row_end) begin
            col_in = '0;
            row_in = grid_end ? '0 : row_plus[IDX_W-1:0];
         end else begin
            col_in = col_plus[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign col_index = col_ff;
   assign flags.first_row = (row_ff == '0);
   assign flags.first_col = (col_ff == '0);
   assign flags.last_cell = grid_end;

endmodule
